@@ rtl/irams_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer package
// Shared codes, widths and the result word type.
// ----------------------------------------------------------------------------
package irams_pkg;

  // Input word kinds
  localparam logic [2:0] KIND_START_WRITE = 3'd0;
  localparam logic [2:0] KIND_START_READ  = 3'd1;
  localparam logic [2:0] KIND_EVENT       = 3'd2;
  localparam logic [2:0] KIND_TICK        = 3'd3;
  localparam logic [2:0] KIND_BYTE        = 3'd4;

  // Engine event codes
  localparam logic [2:0] EV_MODE_SELECT = 3'd0;
  localparam logic [2:0] EV_TX_SELECTED = 3'd1;
  localparam logic [2:0] EV_BYTE_SENT   = 3'd2;
  localparam logic [2:0] EV_RX_SELECTED = 3'd3;
  localparam logic [2:0] EV_BYTE_RECVD  = 3'd4;
  localparam logic [2:0] EV_BUS_FREE    = 3'd5;

  // Actions requested of the engine
  localparam logic [3:0] ACT_NONE      = 4'd0;
  localparam logic [3:0] ACT_START     = 4'd1;
  localparam logic [3:0] ACT_SEND_ADDR = 4'd2;
  localparam logic [3:0] ACT_SEND_DATA = 4'd3;
  localparam logic [3:0] ACT_STOP      = 4'd4;
  localparam logic [3:0] ACT_NACK_STOP = 4'd5;
  localparam logic [3:0] ACT_ACK_ON    = 4'd6;
  localparam logic [3:0] ACT_RECOVER   = 4'd7;
  localparam logic [3:0] ACT_READ_BYTE = 4'd8;
  localparam logic [3:0] ACT_WANT_BYTE = 4'd9;

  // Transaction status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BUSY_TIMEOUT = 3'd1;
  localparam logic [2:0] ST_START        = 3'd2;
  localparam logic [2:0] ST_ADDRESS      = 3'd3;
  localparam logic [2:0] ST_BYTE_SENT    = 3'd4;
  localparam logic [2:0] ST_RESTART      = 3'd5;
  localparam logic [2:0] ST_READ_ADDRESS = 3'd6;
  localparam logic [2:0] ST_RX_TIMEOUT   = 3'd7;

  localparam int unsigned TIMEOUT_BITS  = 10;
  localparam logic [9:0]  TIMEOUT_RESET = 10'd100;
  localparam logic [9:0]  ELAPSED_MAX   = 10'd1023;

  localparam int unsigned OQ_DEPTH    = 4;
  localparam int unsigned OQ_PTR_BITS = 2;
  localparam int unsigned OQ_CNT_BITS = 3;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } res_t;

  // Up to two result words produced by one input word; b is valid only with a.
  typedef struct packed {
    logic valid_a;
    logic valid_b;
    res_t res_a;
    res_t res_b;
  } res_pair_t;

endpackage

@@ rtl/irams_seq.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer: transaction state machine
// Holds the transaction state and turns one input word into up to two
// result words in a single step.
// ----------------------------------------------------------------------------
module irams_seq
  import irams_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  logic [2:0]              kind_i,
  input  logic [7:0]              device_address_i,
  input  logic [7:0]              register_address_i,
  input  logic [15:0]             byte_count_i,
  input  logic [2:0]              event_code_i,
  input  logic [7:0]              data_in_i,
  input  logic [TIMEOUT_BITS-1:0] timeout_ms_i,
  output res_pair_t               res_o
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_BUSY      = 4'd1;
  localparam logic [3:0] PH_W_START   = 4'd2;
  localparam logic [3:0] PH_W_ADDR    = 4'd3;
  localparam logic [3:0] PH_W_REG     = 4'd4;
  localparam logic [3:0] PH_W_WANT    = 4'd5;
  localparam logic [3:0] PH_W_DATA    = 4'd6;
  localparam logic [3:0] PH_R_START   = 4'd7;
  localparam logic [3:0] PH_R_ADDR    = 4'd8;
  localparam logic [3:0] PH_R_REG     = 4'd9;
  localparam logic [3:0] PH_R_RESTART = 4'd10;
  localparam logic [3:0] PH_R_RADDR   = 4'd11;
  localparam logic [3:0] PH_R_DATA    = 4'd12;

  logic [3:0]              phase_q, phase_d;
  logic [7:0]              device_q, device_d;
  logic [7:0]              register_q, register_d;
  logic [COUNT_BITS-1:0]   bytes_left_q, bytes_left_d;
  logic [COUNT_BITS-1:0]   bytes_dec;
  logic [TIMEOUT_BITS-1:0] elapsed_q, elapsed_d;
  logic [TIMEOUT_BITS-1:0] elapsed_inc;
  logic [2:0]              phase_err;

  assign bytes_dec   = bytes_left_q - COUNT_BITS'(1);
  assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 10'd1;

  always_comb begin
    unique case (phase_q)
      PH_BUSY:                               phase_err = ST_BUSY_TIMEOUT;
      PH_W_START, PH_R_START:                phase_err = ST_START;
      PH_W_ADDR, PH_R_ADDR:                  phase_err = ST_ADDRESS;
      PH_W_REG, PH_W_DATA, PH_R_REG:         phase_err = ST_BYTE_SENT;
      PH_R_RESTART:                          phase_err = ST_RESTART;
      PH_R_RADDR:                            phase_err = ST_READ_ADDRESS;
      default:                               phase_err = ST_RX_TIMEOUT;
    endcase
  end

  always_comb begin
    phase_d      = phase_q;
    device_d     = device_q;
    register_d   = register_q;
    bytes_left_d = bytes_left_q;
    elapsed_d    = elapsed_q;
    res_o        = '0;

    if (fire_i) begin
      unique case (kind_i)
        KIND_START_WRITE, KIND_START_READ: begin
          if (phase_q == PH_IDLE) begin
            device_d     = device_address_i;
            register_d   = register_address_i;
            bytes_left_d = COUNT_BITS'(byte_count_i);
            elapsed_d    = '0;
            if (kind_i == KIND_START_WRITE) begin
              res_o.valid_a        = 1'b1;
              res_o.res_a.action   = ACT_START;
              phase_d              = PH_W_START;
            end else begin
              phase_d = PH_BUSY;
            end
          end
        end

        KIND_TICK: begin
          if (phase_q != PH_IDLE && phase_q != PH_W_WANT) begin
            elapsed_d = elapsed_inc;
            if (elapsed_inc >= timeout_ms_i) begin
              // A busy-bus timeout leaves the engine alone; every other one
              // asks for recovery.
              res_o.valid_a      = 1'b1;
              res_o.res_a.action = (phase_q == PH_BUSY) ? ACT_NONE : ACT_RECOVER;
              res_o.res_a.status = phase_err;
              res_o.res_a.last   = 1'b1;
              phase_d            = PH_IDLE;
              elapsed_d          = '0;
            end
          end
        end

        KIND_BYTE: begin
          if (phase_q == PH_W_WANT) begin
            res_o.valid_a        = 1'b1;
            res_o.res_a.action   = ACT_SEND_DATA;
            res_o.res_a.out_byte = data_in_i;
            bytes_left_d         = bytes_dec;
            phase_d              = PH_W_DATA;
            elapsed_d            = '0;
          end
        end

        KIND_EVENT: begin
          unique case (phase_q)
            PH_BUSY: begin
              if (event_code_i == EV_BUS_FREE) begin
                res_o.valid_a      = 1'b1;
                res_o.res_a.action = ACT_START;
                phase_d            = PH_R_START;
                elapsed_d          = '0;
              end
            end
            PH_W_START, PH_R_START: begin
              if (event_code_i == EV_MODE_SELECT) begin
                res_o.valid_a        = 1'b1;
                res_o.res_a.action   = ACT_SEND_ADDR;
                res_o.res_a.out_byte = {device_q[7:1], 1'b0};
                phase_d              = (phase_q == PH_W_START) ? PH_W_ADDR : PH_R_ADDR;
                elapsed_d            = '0;
              end
            end
            PH_W_ADDR, PH_R_ADDR: begin
              if (event_code_i == EV_TX_SELECTED) begin
                res_o.valid_a        = 1'b1;
                res_o.res_a.action   = ACT_SEND_DATA;
                res_o.res_a.out_byte = register_q;
                phase_d              = (phase_q == PH_W_ADDR) ? PH_W_REG : PH_R_REG;
                elapsed_d            = '0;
              end
            end
            PH_W_REG, PH_W_DATA: begin
              if (event_code_i == EV_BYTE_SENT) begin
                res_o.valid_a = 1'b1;
                elapsed_d     = '0;
                if (bytes_left_q == '0) begin
                  res_o.res_a.action = ACT_STOP;
                  res_o.res_a.last   = 1'b1;
                  phase_d            = PH_IDLE;
                end else begin
                  res_o.res_a.action = ACT_WANT_BYTE;
                  phase_d            = PH_W_WANT;
                end
              end
            end
            PH_R_REG: begin
              if (event_code_i == EV_BYTE_SENT) begin
                res_o.valid_a      = 1'b1;
                res_o.res_a.action = ACT_START;
                phase_d            = PH_R_RESTART;
                elapsed_d          = '0;
              end
            end
            PH_R_RESTART: begin
              if (event_code_i == EV_MODE_SELECT) begin
                res_o.valid_a        = 1'b1;
                res_o.res_a.action   = ACT_SEND_ADDR;
                res_o.res_a.out_byte = {device_q[7:1], 1'b1};
                phase_d              = PH_R_RADDR;
                elapsed_d            = '0;
              end
            end
            PH_R_RADDR: begin
              if (event_code_i == EV_RX_SELECTED) begin
                elapsed_d = '0;
                if (bytes_left_q == '0) begin
                  // Nothing to receive: close the bus and restore ACK.
                  res_o.valid_a      = 1'b1;
                  res_o.res_a.action = ACT_STOP;
                  res_o.valid_b      = 1'b1;
                  res_o.res_b.action = ACT_ACK_ON;
                  res_o.res_b.last   = 1'b1;
                  phase_d            = PH_IDLE;
                end else begin
                  res_o.valid_a      = (bytes_left_q == COUNT_BITS'(1));
                  res_o.res_a.action = ACT_NACK_STOP;
                  phase_d            = PH_R_DATA;
                end
              end
            end
            PH_R_DATA: begin
              if (event_code_i == EV_BYTE_RECVD) begin
                res_o.valid_a        = 1'b1;
                res_o.res_a.action   = ACT_READ_BYTE;
                res_o.res_a.out_byte = data_in_i;
                bytes_left_d         = bytes_dec;
                elapsed_d            = '0;
                if (bytes_dec == '0) begin
                  res_o.valid_b      = 1'b1;
                  res_o.res_b.action = ACT_ACK_ON;
                  res_o.res_b.last   = 1'b1;
                  phase_d            = PH_IDLE;
                end else begin
                  res_o.valid_b      = (bytes_dec == COUNT_BITS'(1));
                  res_o.res_b.action = ACT_NACK_STOP;
                end
              end
            end
            default: ;
          endcase
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      device_q     <= '0;
      register_q   <= '0;
      bytes_left_q <= '0;
      elapsed_q    <= '0;
    end else begin
      phase_q      <= phase_d;
      device_q     <= device_d;
      register_q   <= register_d;
      bytes_left_q <= bytes_left_d;
      elapsed_q    <= elapsed_d;
    end
  end

endmodule

@@ rtl/irams_outq.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer: result queue
// Small queue taking up to two result words a cycle and giving one while the consumer is ready.
// ----------------------------------------------------------------------------
module irams_outq
  import irams_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output res_t      head_o
);

  res_t                   entry_q [OQ_DEPTH];
  logic [OQ_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [OQ_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [OQ_CNT_BITS-1:0] count_q, count_d;
  logic [OQ_PTR_BITS-1:0] wr_next;
  logic [OQ_CNT_BITS-1:0] n_push;
  logic                   pop;

  assign wr_next = wr_ptr_q + OQ_PTR_BITS'(1);
  assign pop     = valid_o && ready_i;
  assign n_push  = OQ_CNT_BITS'(push_i.valid_a) + OQ_CNT_BITS'(push_i.valid_b);
  assign wr_ptr_d = wr_ptr_q + OQ_PTR_BITS'(n_push);
  assign rd_ptr_d = rd_ptr_q + OQ_PTR_BITS'(pop);
  assign count_d  = count_q + n_push - OQ_CNT_BITS'(pop);

  // Room for the worst case of one step, from registered state only.
  assign room_o  = count_q <= OQ_CNT_BITS'(OQ_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid_a) begin
      entry_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.valid_b) begin
      entry_q[wr_next] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

@@ rtl/i2c_register_access_master_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C register access master sequencer
// Drives register-addressed read and write transactions on a byte-level I2C
// master engine, with a per-phase millisecond timeout.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle on the slave stream and answers
// with zero, one or two words on the master stream. An accepted word is held
// in an input register, then the transaction state machine consumes it in a
// single step and places its results in a four-word result queue, from which
// the master stream offers them in order. The input side keeps accepting a
// word every cycle as long as the result queue holds no more than two words;
// a slow consumer on the master side therefore stalls the input only once the
// queue holds three words or more. A write transaction issues start, the
// address with the write direction, the register index, then for each data
// byte a request for it and the byte the user supplies, then stop. A read
// transaction first waits for the bus to be free, then issues start, address
// with write direction, register index, repeated start and address with read
// direction, and receives the data bytes, asking for NACK plus stop before
// the last one and turning ACK back on at the end; a read of zero bytes
// issues stop and then turns ACK back on. Every wait for an engine event is
// limited to timeout_ms millisecond ticks; on expiry the transaction ends
// with an error status and a recover action, except for a busy-bus timeout,
// which reports with no action. The timeout register may only be written
// while no transaction is in progress.
// ----------------------------------------------------------------------------
module i2c_register_access_master_sequencer
  import irams_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] device_address, [15:8] register_address, [31:16] byte_count,
  // [34:32] event_code, [42:35] data_in, [47:43] zero
  input  logic [47:0] s_axis_tdata,
  // [2:0] kind
  input  logic [2:0]  s_axis_tuser,
  // Master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_byte, [10:8] status, [15:11] zero
  output logic [15:0] m_axis_tdata,
  // [3:0] action
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  // Configuration: timeout_ms
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [9:0]  cfg_data_i
);

  logic                    in_valid_q;
  logic [47:0]             in_data_q;
  logic [2:0]              in_kind_q;
  logic                    fire;
  logic                    room;
  logic [TIMEOUT_BITS-1:0] timeout_q;
  res_pair_t               step_res;
  res_t                    head;

  // The held word is consumed whenever the queue can take its worst case.
  assign fire          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || fire;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      timeout_q  <= TIMEOUT_RESET;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (cfg_valid_i) begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
      in_kind_q <= s_axis_tuser;
    end
  end

  irams_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .fire_i             (fire),
    .kind_i             (in_kind_q),
    .device_address_i   (in_data_q[7:0]),
    .register_address_i (in_data_q[15:8]),
    .byte_count_i       (in_data_q[31:16]),
    .event_code_i       (in_data_q[34:32]),
    .data_in_i          (in_data_q[42:35]),
    .timeout_ms_i       (timeout_q),
    .res_o              (step_res)
  );

  irams_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .head_o  (head)
  );

  assign m_axis_tdata = {5'd0, head.status, head.out_byte};
  assign m_axis_tuser = head.action;
  assign m_axis_tlast = head.last;

endmodule

@@ rtl/irams_checker.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module irams_checker
  import irams_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result word holds still.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // Status is only reported on the final word of a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[10:8] == ST_OK)
    else $error("status set on a non-final word");

  // Only address, data and read-byte actions carry a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[7:0] != 8'd0 |->
      m_axis_tuser == ACT_SEND_ADDR || m_axis_tuser == ACT_SEND_DATA
      || m_axis_tuser == ACT_READ_BYTE)
    else $error("byte present on an action that carries none");

  // Recovery always ends a transaction with an error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ACT_RECOVER |->
      m_axis_tlast && m_axis_tdata[10:8] != ST_OK
      && m_axis_tdata[10:8] != ST_BUSY_TIMEOUT)
    else $error("recover without a phase timeout status");

  // An empty action only reports a busy-bus timeout.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ACT_NONE |->
      m_axis_tlast && m_axis_tdata[10:8] == ST_BUSY_TIMEOUT)
    else $error("empty action other than a busy timeout");

endmodule

bind i2c_register_access_master_sequencer irams_checker u_irams_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// I2C register access sequencer testbench
// Streams transaction starts, engine events, millisecond ticks and write
// bytes into the sequencer and checks every action word against a cycle-free
// prediction of the transaction state machine.
// ----------------------------------------------------------------------------
module testbench;
  import irams_pkg::*;

  // Settling time after the last expected word, enough for a word that is
  // still in the input register and the state machine to leave no trace.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Generous ceiling on the whole run; the slowest legal run is far shorter.
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned MAX_REPORTS  = 10;

  // Input kinds and event codes that the block must ignore.
  localparam logic [2:0] KIND_RESERVED_LO = 3'd5;
  localparam logic [2:0] KIND_RESERVED_HI = 3'd7;
  localparam logic [2:0] EV_UNDEFINED     = 3'd7;

  // Transaction phases of the predicted sequencer.
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_BUS_WAIT,
    SQ_W_START, SQ_W_ADDR, SQ_W_REG, SQ_W_WANT, SQ_W_DATA,
    SQ_R_START, SQ_R_ADDR, SQ_R_REG, SQ_R_RESTART, SQ_R_RADDR, SQ_R_DATA
  } seq_phase_e;

  // Patterns for the result side's willingness to take words.
  typedef enum logic [1:0] {RX_STEADY, RX_RANDOM, RX_SPARSE} rx_pattern_e;

  // One word on the input stream, field by field.
  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  dev_addr;
    logic [7:0]  reg_addr;
    logic [15:0] byte_count;
    logic [2:0]  event_code;
    logic [7:0]  data_byte;
  } bus_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [7:0] device_address, [15:8] register_address, [31:16] byte_count,
  // [34:32] event_code, [42:35] data_in, [47:43] zero
  logic [47:0] s_axis_tdata  = '0;
  // [2:0] kind
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] out_byte, [10:8] status, [15:11] zero
  logic [15:0] m_axis_tdata;
  // [3:0] action
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [9:0]  cfg_data_i    = '0;

  // Stimulus waiting for the driver, and action words still owed by the block.
  bus_word_t   pending_words[$];
  res_t        expected_actions[$];
  bus_word_t   cur_word;
  bit          word_on_bus = 1'b0;
  bit          took_word   = 1'b0;
  int unsigned words_queued = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned rx_count     = 0;
  rx_pattern_e rx_pattern   = RX_STEADY;
  int unsigned mismatches   = 0;
  int unsigned cycle_count  = 0;

  // Predicted sequencer state, including our copy of the timeout register.
  seq_phase_e  model_phase      = SQ_IDLE;
  logic [7:0]  model_device     = '0;
  logic [7:0]  model_register   = '0;
  logic [15:0] model_bytes_left = '0;
  logic [9:0]  model_elapsed    = '0;
  logic [9:0]  timeout_copy     = TIMEOUT_RESET;

  i2c_register_access_master_sequencer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Prediction of the transaction state machine
  // --------------------------------------------------------------------------

  function automatic void expect_word(logic [3:0] action, logic [7:0] value,
                                      logic [2:0] status, logic last);
    res_t r;
    r.action   = action;
    r.out_byte = value;
    r.status   = status;
    r.last     = last;
    expected_actions.push_back(r);
  endfunction

  // Every phase change restarts the millisecond count of the new wait.
  function automatic void enter_phase(seq_phase_e p);
    model_phase   = p;
    model_elapsed = '0;
  endfunction

  // Error status reported when the wait of a given phase runs out.
  function automatic logic [2:0] timeout_status(seq_phase_e p);
    case (p)
      SQ_BUS_WAIT:                            return ST_BUSY_TIMEOUT;
      SQ_W_START, SQ_R_START:                 return ST_START;
      SQ_W_ADDR, SQ_R_ADDR:                   return ST_ADDRESS;
      SQ_W_REG, SQ_W_DATA, SQ_R_REG:          return ST_BYTE_SENT;
      SQ_R_RESTART:                           return ST_RESTART;
      SQ_R_RADDR:                             return ST_READ_ADDRESS;
      default:                                return ST_RX_TIMEOUT;
    endcase
  endfunction

  // On a received data byte, or on the receiver being selected: either the
  // read is complete (ACK back on) or the next byte may be the last, in which
  // case NACK plus stop has to be requested before it arrives.
  function automatic void read_progress();
    if (model_bytes_left == '0) begin
      expect_word(ACT_ACK_ON, 8'h00, ST_OK, 1'b1);
      enter_phase(SQ_IDLE);
    end else begin
      if (model_bytes_left == 16'd1) expect_word(ACT_NACK_STOP, 8'h00, ST_OK, 1'b0);
      enter_phase(SQ_R_DATA);
    end
  endfunction

  function automatic void advance_on_event(logic [2:0] ev, logic [7:0] data);
    case (model_phase)
      SQ_BUS_WAIT: if (ev == EV_BUS_FREE) begin
        expect_word(ACT_START, 8'h00, ST_OK, 1'b0);
        enter_phase(SQ_R_START);
      end
      SQ_W_START, SQ_R_START: if (ev == EV_MODE_SELECT) begin
        expect_word(ACT_SEND_ADDR, {model_device[7:1], 1'b0}, ST_OK, 1'b0);
        enter_phase(model_phase == SQ_W_START ? SQ_W_ADDR : SQ_R_ADDR);
      end
      SQ_W_ADDR, SQ_R_ADDR: if (ev == EV_TX_SELECTED) begin
        expect_word(ACT_SEND_DATA, model_register, ST_OK, 1'b0);
        enter_phase(model_phase == SQ_W_ADDR ? SQ_W_REG : SQ_R_REG);
      end
      SQ_W_REG, SQ_W_DATA: if (ev == EV_BYTE_SENT) begin
        // A write of zero bytes stops straight after the register index.
        if (model_bytes_left == '0) begin
          expect_word(ACT_STOP, 8'h00, ST_OK, 1'b1);
          enter_phase(SQ_IDLE);
        end else begin
          expect_word(ACT_WANT_BYTE, 8'h00, ST_OK, 1'b0);
          enter_phase(SQ_W_WANT);
        end
      end
      SQ_R_REG: if (ev == EV_BYTE_SENT) begin
        expect_word(ACT_START, 8'h00, ST_OK, 1'b0);
        enter_phase(SQ_R_RESTART);
      end
      SQ_R_RESTART: if (ev == EV_MODE_SELECT) begin
        expect_word(ACT_SEND_ADDR, {model_device[7:1], 1'b1}, ST_OK, 1'b0);
        enter_phase(SQ_R_RADDR);
      end
      SQ_R_RADDR: if (ev == EV_RX_SELECTED) begin
        // A read of zero bytes needs a stop before ACK is turned back on.
        if (model_bytes_left == '0) expect_word(ACT_STOP, 8'h00, ST_OK, 1'b0);
        read_progress();
      end
      SQ_R_DATA: if (ev == EV_BYTE_RECVD) begin
        expect_word(ACT_READ_BYTE, data, ST_OK, 1'b0);
        model_bytes_left = model_bytes_left - 16'd1;
        read_progress();
      end
      default: ;
    endcase
  endfunction

  // Works out the action words that one accepted input word gives rise to.
  function automatic void predict_engine_actions(bus_word_t w);
    case (w.kind)
      KIND_START_WRITE, KIND_START_READ: if (model_phase == SQ_IDLE) begin
        model_device     = w.dev_addr;
        model_register   = w.reg_addr;
        model_bytes_left = w.byte_count;
        if (w.kind == KIND_START_WRITE) begin
          expect_word(ACT_START, 8'h00, ST_OK, 1'b0);
          enter_phase(SQ_W_START);
        end else begin
          enter_phase(SQ_BUS_WAIT);
        end
      end
      KIND_TICK: if (model_phase != SQ_IDLE && model_phase != SQ_W_WANT) begin
        if (model_elapsed != ELAPSED_MAX) model_elapsed = model_elapsed + 10'd1;
        // A busy bus that never frees up is reported without any action.
        if (model_elapsed >= timeout_copy) begin
          expect_word(model_phase == SQ_BUS_WAIT ? ACT_NONE : ACT_RECOVER, 8'h00,
                      timeout_status(model_phase), 1'b1);
          enter_phase(SQ_IDLE);
        end
      end
      KIND_BYTE: if (model_phase == SQ_W_WANT) begin
        expect_word(ACT_SEND_DATA, w.data_byte, ST_OK, 1'b0);
        model_bytes_left = model_bytes_left - 16'd1;
        enter_phase(SQ_W_DATA);
      end
      KIND_EVENT: advance_on_event(w.event_code, w.data_byte);
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------

  function automatic void queue_word(logic [2:0] kind, logic [7:0] dev, logic [7:0] reg_a,
                                     logic [15:0] count, logic [2:0] ev, logic [7:0] data);
    bus_word_t w;
    w.kind       = kind;
    w.dev_addr   = dev;
    w.reg_addr   = reg_a;
    w.byte_count = count;
    w.event_code = ev;
    w.data_byte  = data;
    pending_words.push_back(w);
    words_queued++;
  endfunction

  // Fields that a kind does not use are filled at random, so that they are
  // seen to have no effect.
  function automatic void queue_start(logic [2:0] kind, logic [7:0] dev, logic [7:0] reg_a,
                                      logic [15:0] count);
    queue_word(kind, dev, reg_a, count, 3'($urandom), 8'($urandom));
  endfunction

  function automatic void queue_event(logic [2:0] ev, logic [7:0] data);
    queue_word(KIND_EVENT, 8'($urandom), 8'($urandom), 16'($urandom), ev, data);
  endfunction

  function automatic void queue_byte(logic [7:0] data);
    queue_word(KIND_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), 3'($urandom), data);
  endfunction

  function automatic void queue_ticks(int unsigned n);
    repeat (n)
      queue_word(KIND_TICK, 8'($urandom), 8'($urandom), 16'($urandom), 3'($urandom),
                 8'($urandom));
  endfunction

  // A word of any kind that is not a start: ignored when idle.
  function automatic void queue_noise();
    queue_word(3'($urandom_range(KIND_EVENT, KIND_RESERVED_HI)), 8'($urandom),
               8'($urandom), 16'($urandom),
               3'($urandom_range(EV_MODE_SELECT, EV_UNDEFINED)), 8'($urandom));
  endfunction

  // Disturbances that a careless sequence carries between its steps: ticks
  // that may run a wait out, and starts that arrive while busy.
  function automatic void disturb(bit sloppy);
    if (sloppy) begin
      if ($urandom_range(0, 3) == 0) queue_ticks($urandom_range(1, 2));
      if ($urandom_range(0, 9) == 0)
        queue_start(3'($urandom_range(KIND_START_WRITE, KIND_START_READ)), 8'($urandom),
                    8'($urandom), 16'($urandom_range(0, 3)));
    end
  endfunction

  // One engine event in sequence; a careless sequence sometimes loses it,
  // which leaves the block waiting until a timeout frees it.
  function automatic void step_event(logic [2:0] ev, bit sloppy);
    disturb(sloppy);
    if (!sloppy || $urandom_range(0, 11) != 0) queue_event(ev, 8'($urandom));
  endfunction

  // A complete transaction as the engine would answer it. Very long counts
  // are served for two bytes only and then abandoned through a timeout.
  function automatic void queue_transaction(bit read, bit sloppy);
    logic [15:0] count;
    int unsigned served;
    if (timeout_copy <= 10'd16 && $urandom_range(0, 9) == 0) count = 16'($urandom);
    else if ($urandom_range(0, 4) == 0) count = 16'($urandom_range(4, 6));
    else count = 16'($urandom_range(0, 3));
    served = (count > 16'd6) ? 2 : count;
    queue_start(read ? KIND_START_READ : KIND_START_WRITE, 8'($urandom), 8'($urandom),
                count);
    if (read) step_event(EV_BUS_FREE, sloppy);
    step_event(EV_MODE_SELECT, sloppy);
    step_event(EV_TX_SELECTED, sloppy);
    step_event(EV_BYTE_SENT, sloppy);
    if (read) begin
      step_event(EV_MODE_SELECT, sloppy);
      step_event(EV_RX_SELECTED, sloppy);
      repeat (served) step_event(EV_BYTE_RECVD, sloppy);
    end else begin
      repeat (served) begin
        disturb(sloppy);
        queue_byte(8'($urandom));
        step_event(EV_BYTE_SENT, sloppy);
      end
    end
    if (served != count) begin
      if (!read) queue_byte(8'($urandom));
      queue_ticks(timeout_copy + 1);
    end
  endfunction

  function automatic void queue_random_traffic(int unsigned n, bit allow_sloppy);
    int unsigned stop_at;
    stop_at = words_queued + n;
    while (words_queued < stop_at) begin
      if ($urandom_range(0, 4) == 0) queue_noise();
      else queue_transaction(1'($urandom_range(0, 1)),
                             allow_sloppy && $urandom_range(0, 2) == 0);
    end
  endfunction

  // Holds until every queued word has gone in and every action word has come
  // out, then gives the block time to finish any word that causes nothing.
  // If a transaction is still open it is brought to an end: a write byte in
  // case one is wanted, then enough ticks for any wait to run out.
  task automatic settle_block();
    do begin
      while (pending_words.size() != 0 || word_on_bus || expected_actions.size() != 0)
        @(posedge clk_i);
      repeat (DRAIN_CYCLES) @(posedge clk_i);
      if (model_phase != SQ_IDLE) begin
        queue_byte(8'($urandom));
        queue_ticks(timeout_copy + 1);
      end
    end while (model_phase != SQ_IDLE);
  endtask

  // Writes the timeout register; only ever called with the block idle.
  task automatic write_timeout(logic [9:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    timeout_copy = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stream driver: words go out in bursts of random length with random gaps
  // between them, and a word stays on the bus until it has been taken.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (word_on_bus && !took_word) begin
        // Still waiting for the block to take the current word.
      end else if (gap_left > 0 || pending_words.size() == 0) begin
        word_on_bus = 1'b0;
        s_axis_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur_word = pending_words.pop_front();
        word_on_bus = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cur_word.kind;
        s_axis_tdata  <= {5'b0, cur_word.data_byte, cur_word.event_code,
                          cur_word.byte_count, cur_word.reg_addr, cur_word.dev_addr};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 11);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result side: readiness follows a randomly chosen pattern, from always
  // ready through random stalls to a sparse, periodic one.
  always @(negedge clk_i) begin
    rx_count++;
    if (rx_count % 40 == 0) rx_pattern = rx_pattern_e'($urandom_range(0, 2));
    case (rx_pattern)
      RX_STEADY: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= (rx_count % 4 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on every word taken in and checks every word given out.
  // --------------------------------------------------------------------------
  function automatic void report_result(bit owed, res_t want, res_t seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (owed)
        $display("%0t: action word mismatch: expected action %0d byte %02h status %0d last %0d,",
                 $realtime, want.action, want.out_byte, want.status, want.last,
                 " got action %0d byte %02h status %0d last %0d",
                 seen.action, seen.out_byte, seen.status, seen.last);
      else
        $display("%0t: unexpected action word: action %0d byte %02h status %0d last %0d",
                 $realtime, seen.action, seen.out_byte, seen.status, seen.last);
    end
  endfunction

  always @(posedge clk_i) begin : watch_streams
    res_t seen;
    res_t want;
    if (rst_ni) begin
      took_word = s_axis_tvalid && s_axis_tready;
      if (took_word) predict_engine_actions(cur_word);
      if (m_axis_tvalid && m_axis_tready) begin
        seen.action   = m_axis_tuser;
        seen.out_byte = m_axis_tdata[7:0];
        seen.status   = m_axis_tdata[10:8];
        seen.last     = m_axis_tlast;
        if (expected_actions.size() == 0) begin
          report_result(1'b0, seen, seen);
        end else begin
          want = expected_actions.pop_front();
          if (seen.action != want.action || seen.out_byte != want.out_byte ||
              seen.status != want.status || seen.last != want.last)
            report_result(1'b1, want, seen);
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing action word ends up here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, with the timeout left at its reset value. Words that
    // must be ignored come first: a reserved kind, and a tick, an event and
    // a write byte while idle.
    queue_word(KIND_RESERVED_LO, 8'hFF, 8'hFF, 16'hFFFF, EV_UNDEFINED, 8'hFF);
    queue_ticks(1);
    queue_event(EV_BYTE_SENT, 8'h3C);
    queue_byte(8'hC3);
    // A one-byte write to the highest address, with a start arriving while
    // busy and a tick while a write byte is awaited (neither has an effect).
    queue_start(KIND_START_WRITE, 8'hFF, 8'h00, 16'd1);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_TX_SELECTED, 8'h00);
    queue_start(KIND_START_READ, 8'h12, 8'h34, 16'd2);
    queue_event(EV_BYTE_SENT, 8'h00);
    queue_ticks(1);
    queue_byte(8'hA5);
    queue_event(EV_BYTE_SENT, 8'h00);
    // A write of no bytes stops right after the register index.
    queue_start(KIND_START_WRITE, 8'h00, 8'hFF, 16'd0);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_TX_SELECTED, 8'h00);
    queue_event(EV_BYTE_SENT, 8'h00);
    // A two-byte read, with an undefined event code while the bus is busy.
    queue_start(KIND_START_READ, 8'h55, 8'hAA, 16'd2);
    queue_event(EV_UNDEFINED, 8'h00);
    queue_event(EV_BUS_FREE, 8'h00);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_TX_SELECTED, 8'h00);
    queue_event(EV_BYTE_SENT, 8'h00);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_RX_SELECTED, 8'h00);
    queue_event(EV_BYTE_RECVD, 8'hFF);
    queue_event(EV_BYTE_RECVD, 8'h00);
    settle_block();

    // A zero timeout expires on the very first tick of any wait.
    write_timeout(10'd0);
    queue_start(KIND_START_READ, 8'hAB, 8'h5A, 16'd0);
    queue_event(EV_BUS_FREE, 8'h00);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_TX_SELECTED, 8'h00);
    queue_event(EV_BYTE_SENT, 8'h00);
    queue_event(EV_MODE_SELECT, 8'h00);
    queue_event(EV_RX_SELECTED, 8'h00);
    queue_start(KIND_START_READ, 8'h01, 8'h80, 16'hFFFF);
    queue_ticks(1);
    queue_start(KIND_START_WRITE, 8'h80, 8'h01, 16'hFFFF);
    queue_ticks(1);
    queue_random_traffic(10, 1'b1);
    settle_block();

    // Short timeouts make careless sequences run out in every timed phase.
    write_timeout(10'd3);
    queue_random_traffic(20, 1'b1);
    settle_block();

    // The longest timeout, with clean traffic only.
    write_timeout(10'd1023);
    queue_random_traffic(15, 1'b0);
    settle_block();

    write_timeout(10'd1);
    queue_random_traffic(10, 1'b1);
    settle_block();

    write_timeout(10'd12);
    queue_random_traffic(15, 1'b1);
    settle_block();

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
